[hdl/swp_pkg.sv]
// Shared types and constants for the sliding window pair generator.
// No dependencies; used by swp_front, swp_back and the top level.
package swp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CFG_W       = 5;

  localparam logic CMD_TOKEN = 1'b0;
  localparam logic CMD_EOS   = 1'b1;

  // Head of the item queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic eos;
  } q_status_t;

endpackage

[hdl/swp_front.sv]
// Front end: accepts input items, classifies them and holds them in a short queue.
// Depends on swp_pkg.
module swp_front #(
  parameter int ID_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [ID_BITS-1:0]   token_id,
  output swp_pkg::q_status_t   q_status,
  output logic [ID_BITS-1:0]   q_token,
  input  logic                 q_pop
);

  localparam int CNT_W = $clog2(swp_pkg::QUEUE_DEPTH + 1);

  logic [ID_BITS-1:0]              tok_mem [swp_pkg::QUEUE_DEPTH];
  logic                            eos_mem [swp_pkg::QUEUE_DEPTH];
  logic [swp_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [swp_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]                count;
  logic                            push;
  logic                            pop;

  assign in_stall = (count == CNT_W'(swp_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count != '0);

  assign q_status.valid = (count != '0);
  assign q_status.eos   = eos_mem[rd_ptr];
  assign q_token        = tok_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      tok_mem[wr_ptr] <= token_id;
      eos_mem[wr_ptr] <= (cmd == swp_pkg::CMD_EOS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/swp_back.sv]
// Back end: window memory, pair sequencer and output register.
// Depends on swp_pkg; fed by swp_front through the item queue.
module swp_back #(
  parameter int WINDOW_MAX = 16,
  parameter int ID_BITS    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [swp_pkg::CFG_W-1:0] cfg_data,
  input  swp_pkg::q_status_t        q_status,
  input  logic [ID_BITS-1:0]        q_token,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ID_BITS-1:0]        first_id,
  output logic [ID_BITS-1:0]        second_id,
  output logic                      last
);

  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = FILL_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_EMIT_A = 3'd2;
  localparam logic [2:0] S_EMIT_B = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;

  logic [ID_BITS-1:0] mem [WINDOW_MAX];
  logic [ID_BITS-1:0] rd_data;
  logic [ID_BITS-1:0] tok;
  logic [2:0]         state;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  idx;
  logic [FILL_W-1:0]  size_eff;
  logic [FILL_W-1:0]  cfg_size;
  logic [SUM_W-1:0]   sum;
  logic [PTR_W-1:0]   wr_addr;
  logic               mem_we;
  logic               load_ok;
  logic               last_entry;
  logic               emit;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
  endfunction

  // Clamp the written size to 1..WINDOW_MAX
  always_comb begin
    if (cfg_data == '0) begin
      cfg_size = FILL_W'(1);
    end else if (32'(cfg_data) > 32'(WINDOW_MAX)) begin
      cfg_size = FILL_W'(WINDOW_MAX);
    end else begin
      cfg_size = FILL_W'(cfg_data);
    end
  end

  // Slot just past the newest entry, modulo the memory depth
  always_comb begin
    sum = SUM_W'(head) + SUM_W'(fill);
    if (sum >= SUM_W'(WINDOW_MAX)) begin
      sum = sum - SUM_W'(WINDOW_MAX);
    end
    wr_addr = sum[PTR_W-1:0];
  end

  assign load_ok    = !out_valid || !out_stall;
  assign last_entry = (idx == fill - 1'b1);
  assign mem_we     = (state == S_APPEND);
  assign q_pop      = (state == S_IDLE) && q_status.valid;
  assign emit       = (state == S_EMIT_A) || (state == S_EMIT_B);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= tok;
    rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      size_eff  <= FILL_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (load_ok) out_valid <= emit;
      case (state)
        S_IDLE: begin
          if (q_status.valid) begin
            tok    <= q_token;
            idx    <= '0;
            rd_ptr <= head;
            if (q_status.eos) begin
              fill <= '0;
            end else if (fill == '0) begin
              state <= S_APPEND;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_EMIT_A;
        end
        S_EMIT_A: begin
          if (load_ok) begin
            first_id  <= tok;
            second_id <= rd_data;
            last      <= 1'b0;
            state     <= S_EMIT_B;
          end
        end
        S_EMIT_B: begin
          if (load_ok) begin
            first_id  <= rd_data;
            second_id <= tok;
            last      <= last_entry;
            if (last_entry) begin
              state <= S_APPEND;
            end else begin
              idx    <= idx + 1'b1;
              rd_ptr <= wrap_inc(rd_ptr);
              state  <= S_FETCH;
            end
          end
        end
        S_APPEND: begin
          // full window: drop the oldest entry by advancing head past it
          if (fill >= size_eff) begin
            head <= wrap_inc(head);
          end else begin
            fill <= fill + 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        size_eff <= cfg_size;
        fill     <= '0;
      end
    end
  end

endmodule

[hdl/sliding_window_pair_generator.sv]
// Top level of the sliding window pair generator: front queue plus back sequencer.
// Depends on swp_pkg, swp_front and swp_back.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   input   | in_valid / in_stall  | cmd, token_id
//   output  | out_valid / out_stall| first_id, second_id, last
//   config  | cfg_we               | cfg_data (window_size)
//
// For each token the back end pops it, then for every entry in the window fetches
// that entry from the single read port of the window memory and emits two pairs,
// then appends the token. An end-of-sentence item is popped and empties the window.
// Output stalls hold the back end in its emit states.
// Reset is synchronous: window empty, size 1, queue empty, no item pending.
// The input stalls only while the four-entry queue is full.
module sliding_window_pair_generator #(
  parameter int WINDOW_MAX = 16,
  parameter int ID_BITS    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [swp_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      cmd,
  input  logic [ID_BITS-1:0]        token_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ID_BITS-1:0]        first_id,
  output logic [ID_BITS-1:0]        second_id,
  output logic                      last
);

  swp_pkg::q_status_t q_status;
  logic [ID_BITS-1:0] q_token;
  logic               q_pop;

  swp_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .token_id (token_id),
    .q_status (q_status),
    .q_token  (q_token),
    .q_pop    (q_pop)
  );

  swp_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .ID_BITS    (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_token   (q_token),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .first_id  (first_id),
    .second_id (second_id),
    .last      (last)
  );

endmodule
